FILE: rtl/snow_pixel_tree_classifier_unit_macros.svh
// Assertion helpers shared by the checker files.
`ifndef SNOW_PIXEL_TREE_CLASSIFIER_UNIT_MACROS_SVH
`define SNOW_PIXEL_TREE_CLASSIFIER_UNIT_MACROS_SVH
// Same-cycle implication, sampled on clk_i and off during reset.
`define SPTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sptc check failed");
// Next-cycle implication, sampled on clk_i and off during reset.
`define SPTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sptc check failed");
`endif

FILE: rtl/sptc_pkg.sv
package sptc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RAW_W     = 16;
  localparam int SCALE_W   = 32;
  localparam int PROD_W    = RAW_W + SCALE_W;
  localparam int SHIFT     = SCALE_W - FRAC_BITS;
  localparam int BAND_W    = PROD_W - SHIFT;
  localparam int NUM_W     = BAND_W + 1;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int QS_W      = FRAC_BITS + 2;
  localparam int PCT_W     = Q_W + 7;
  localparam int NBANDS    = 7;

  localparam int B_BLUE    = 0;
  localparam int B_GREEN   = 1;
  localparam int B_RED     = 2;
  localparam int B_NIR     = 3;
  localparam int B_SWIR1   = 4;
  localparam int B_THERMAL = 5;
  localparam int B_SWIR2   = 6;

  localparam logic signed [BAND_W-1:0] ONE_FX = BAND_W'(64'sd1 <<< FRAC_BITS);

  // Thresholds are the decimal constants rounded half up to FRAC_BITS fraction bits.
  localparam logic signed [BAND_W-1:0] TH_0P11   =
    BAND_W'((64'sd11 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_24P85  =
    BAND_W'((64'sd2485 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_18P85  =
    BAND_W'((64'sd1885 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_0P072  =
    BAND_W'((64'sd72 * (64'sd1 <<< FRAC_BITS) * 2 + 1000) / 2000);
  localparam logic signed [BAND_W-1:0] TH_0P35   =
    BAND_W'((64'sd35 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_0P042  =
    BAND_W'((64'sd42 * (64'sd1 <<< FRAC_BITS) * 2 + 1000) / 2000);
  localparam logic signed [BAND_W-1:0] TH_0P0432 =
    BAND_W'((64'sd432 * (64'sd1 <<< FRAC_BITS) * 2 + 10000) / 20000);
  localparam logic signed [BAND_W-1:0] TH_0P14   =
    BAND_W'((64'sd14 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_0P32   =
    BAND_W'((64'sd32 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_0P30   =
    BAND_W'((64'sd30 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_0P22   =
    BAND_W'((64'sd22 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_0P10   =
    BAND_W'((64'sd10 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [BAND_W-1:0] TH_0P34   =
    BAND_W'((64'sd34 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);

  localparam logic signed [QS_W-1:0] TQ_0P25 =
    QS_W'((64'sd25 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [QS_W-1:0] TQ_0P21 =
    QS_W'((64'sd21 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [QS_W-1:0] TQ_0P15 =
    QS_W'((64'sd15 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [QS_W-1:0] TQ_0P19 =
    QS_W'((64'sd19 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [QS_W-1:0] TQ_0P57 =
    QS_W'((64'sd57 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);
  localparam logic signed [QS_W-1:0] TQ_0P18 =
    QS_W'((64'sd18 * (64'sd1 <<< FRAC_BITS) * 2 + 100) / 200);

  localparam logic [6:0] PROB_MASKED = 7'd0;
  localparam logic [6:0] PROB_HOT    = 7'd2;
  localparam logic [6:0] PROB_EXIT   = 7'd3;
  localparam logic [6:0] PROB_FIRM   = 7'd98;

  typedef enum logic [1:0] {
    CFG_REFL_SCALE = 2'd0,
    CFG_TEMP_SCALE = 2'd1,
    CFG_SAT_CODE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic b5_ge_0p072;
    logic b3_lt_0p35;
    logic b1_lt_0p11;
    logic b3_lt_0p042;
    logic b7_ge_0p14;
    logic b4_lt_0p32;
    logic b1_lt_0p30;
    logic b1_lt_0p35;
    logic b7_ge_0p22;
    logic b5_ge_0p10;
    logic b7_ge_0p11;
    logic b1_lt_0p34;
    logic b3_lt_0p0432;
    logic hot;
  } cmp_t;

  typedef struct packed {
    logic masked;
    logic last;
    logic early;
    logic ndsi_neg;
    logic ndvi_neg;
    cmp_t cmp;
  } side_t;

  function automatic logic [7:0] pct(input logic neg, input logic [Q_W-1:0] mag);
    logic [PCT_W-1:0] v;
    v = (PCT_W'(mag) * PCT_W'(100) + PCT_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) return 8'd0;
    if (v > PCT_W'(255)) return 8'd255;
    return v[7:0];
  endfunction

endpackage

FILE: rtl/snow_pixel_tree_classifier_unit.sv
// Snow pixel classifier, one pixel item in, one result item out.
// Input channel: in_valid_i / in_ready_o with seven raw bands, a QA mask bit
// and an end-of-image marker. Output channel: out_valid_o / out_ready_i with
// the snow flag, probability, tree leaf and NDSI / NDVI percents.
// Configuration channel: cfg_valid_i / cfg_ready_o with a register index and
// 32-bit data; cfg_ready_o is always high and index 3 is ignored. Write it
// only while no item is in flight.
// Pipeline registers, in order: the band scaling multipliers, the thresholds
// and quotient operands, the two restoring dividers (one quotient bit per
// stage) and the decision tree into the output register.
// Throughput is one item per cycle. The whole pipeline advances together
// whenever the output register is empty or being taken, so a stalled
// receiver freezes every stage and in_ready_o drops; nothing is lost.
// Reset clears all valid bits and loads the scale and saturation registers
// with their defaults.
module snow_pixel_tree_classifier_unit import sptc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [RAW_W-1:0]  band_blue_i,
  input  logic signed [RAW_W-1:0]  band_green_i,
  input  logic signed [RAW_W-1:0]  band_red_i,
  input  logic signed [RAW_W-1:0]  band_nir_i,
  input  logic signed [RAW_W-1:0]  band_swir1_i,
  input  logic signed [RAW_W-1:0]  band_thermal_i,
  input  logic signed [RAW_W-1:0]  band_swir2_i,
  input  logic                     qa_masked_i,
  input  logic                     last_pixel_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     snow_flag_o,
  output logic [6:0]               probability_o,
  output logic [7:0]               tree_leaf_o,
  output logic [7:0]               ndsi_percent_o,
  output logic [7:0]               ndvi_percent_o,
  output logic                     last_pixel_out_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i
);

  logic               en;
  logic [SCALE_W-1:0] refl_scale_q, temp_scale_q;
  logic [RAW_W-1:0]   sat_code_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refl_scale_q <= 32'd429497;
      temp_scale_q <= 32'd429496730;
      sat_code_q   <= 16'd20000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_REFL_SCALE: refl_scale_q <= cfg_data_i;
        CFG_TEMP_SCALE: temp_scale_q <= cfg_data_i;
        CFG_SAT_CODE:   sat_code_q   <= cfg_data_i[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: scale multipliers.
  logic signed [RAW_W-1:0]  raw [NBANDS];
  logic signed [PROD_W-1:0] p_d [NBANDS];
  logic [NBANDS-1:0]        satb_d;
  logic signed [PROD_W-1:0] p_q [NBANDS];
  logic [NBANDS-1:0]        satb_q;
  logic                     v1_q, masked1_q, last1_q;

  always_comb begin
    raw[B_BLUE]    = band_blue_i;
    raw[B_GREEN]   = band_green_i;
    raw[B_RED]     = band_red_i;
    raw[B_NIR]     = band_nir_i;
    raw[B_SWIR1]   = band_swir1_i;
    raw[B_THERMAL] = band_thermal_i;
    raw[B_SWIR2]   = band_swir2_i;
    for (int i = 0; i < NBANDS; i++) begin
      if (i == B_THERMAL) begin
        p_d[i]    = PROD_W'($signed(raw[i]) * $signed({1'b0, temp_scale_q}));
        satb_d[i] = 1'b0;
      end else begin
        p_d[i]    = PROD_W'($signed(raw[i]) * $signed({1'b0, refl_scale_q}));
        satb_d[i] = raw[i] == sat_code_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q       <= p_d;
      satb_q    <= satb_d;
      masked1_q <= qa_masked_i;
      last1_q   <= last_pixel_in_i;
    end
  end

  // Stage 2: fixed-point bands, exits, thresholds and quotient operands.
  logic signed [BAND_W-1:0] b [NBANDS];
  logic signed [NUM_W-1:0]  sn, sd, vn, vd;
  side_t                    side2_d, side2_q;
  logic [NUM_W-1:0]         sn_q, sd_q, vn_q, vd_q;
  logic                     v2_q;

  always_comb begin
    for (int i = 0; i < NBANDS; i++) begin
      // Arithmetic shift gives the floor, which matches the negative rounding.
      b[i] = satb_q[i] ? ONE_FX : BAND_W'(p_q[i] >>> SHIFT);
    end
    sn = NUM_W'(b[B_GREEN]) - NUM_W'(b[B_SWIR1]);
    sd = NUM_W'(b[B_GREEN]) + NUM_W'(b[B_SWIR1]);
    vn = NUM_W'(b[B_NIR])   - NUM_W'(b[B_RED]);
    vd = NUM_W'(b[B_NIR])   + NUM_W'(b[B_RED]);
    side2_d.masked = masked1_q;
    side2_d.last   = last1_q;
    side2_d.early  = (b[B_NIR] < TH_0P11) || (b[B_THERMAL] > TH_24P85)
                  || (b[B_GREEN] == '0 && b[B_SWIR1] == '0)
                  || (b[B_RED] == '0 && b[B_NIR] == '0);
    // With a zero denominator the quotient takes the numerator's sign.
    side2_d.ndsi_neg = (sd == '0) ? sn[NUM_W-1] : (sn[NUM_W-1] ^ sd[NUM_W-1]);
    side2_d.ndvi_neg = (vd == '0) ? vn[NUM_W-1] : (vn[NUM_W-1] ^ vd[NUM_W-1]);
    side2_d.cmp.b5_ge_0p072  = b[B_SWIR1] >= TH_0P072;
    side2_d.cmp.b3_lt_0p35   = b[B_RED]   <  TH_0P35;
    side2_d.cmp.b1_lt_0p11   = b[B_BLUE]  <  TH_0P11;
    side2_d.cmp.b3_lt_0p042  = b[B_RED]   <  TH_0P042;
    side2_d.cmp.b7_ge_0p14   = b[B_SWIR2] >= TH_0P14;
    side2_d.cmp.b4_lt_0p32   = b[B_NIR]   <  TH_0P32;
    side2_d.cmp.b1_lt_0p30   = b[B_BLUE]  <  TH_0P30;
    side2_d.cmp.b1_lt_0p35   = b[B_BLUE]  <  TH_0P35;
    side2_d.cmp.b7_ge_0p22   = b[B_SWIR2] >= TH_0P22;
    side2_d.cmp.b5_ge_0p10   = b[B_SWIR1] >= TH_0P10;
    side2_d.cmp.b7_ge_0p11   = b[B_SWIR2] >= TH_0P11;
    side2_d.cmp.b1_lt_0p34   = b[B_BLUE]  <  TH_0P34;
    side2_d.cmp.b3_lt_0p0432 = b[B_RED]   <  TH_0P0432;
    side2_d.cmp.hot          = b[B_THERMAL] > TH_18P85;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side2_d;
      sn_q    <= sn[NUM_W-1] ? NUM_W'(-sn) : NUM_W'(sn);
      sd_q    <= sd[NUM_W-1] ? NUM_W'(-sd) : NUM_W'(sd);
      vn_q    <= vn[NUM_W-1] ? NUM_W'(-vn) : NUM_W'(vn);
      vd_q    <= vd[NUM_W-1] ? NUM_W'(-vd) : NUM_W'(vd);
    end
  end

  // Divider stages, with the item's side information riding alongside.
  logic [Q_W-1:0] ndsi_mag, ndvi_mag;
  side_t          side_q [FRAC_BITS+1];
  logic           vdiv_q [FRAC_BITS+1];

  sptc_div u_div_ndsi (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sn_q),
    .den_i (sd_q),
    .quo_o (ndsi_mag)
  );

  sptc_div u_div_ndvi (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (vn_q),
    .den_i (vd_q),
    .quo_o (ndvi_mag)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side2_q;
      for (int i = 1; i <= FRAC_BITS; i++) side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int i = 0; i <= FRAC_BITS; i++) vdiv_q[i] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      vdiv_q[0] <= v2_q;
      for (int i = 1; i <= FRAC_BITS; i++) vdiv_q[i] <= vdiv_q[i-1];
      out_valid_o <= vdiv_q[FRAC_BITS];
    end
  end

  // Final stage: decision tree, thermal post-test and percents.
  side_t                  sf;
  logic signed [QS_W-1:0] ndsi, ndvi;
  logic                   flag;
  logic [6:0]             prob;
  logic [7:0]             leaf;

  always_comb begin
    sf   = side_q[FRAC_BITS];
    ndsi = sf.ndsi_neg ? -QS_W'(ndsi_mag) : QS_W'(ndsi_mag);
    ndvi = sf.ndvi_neg ? -QS_W'(ndvi_mag) : QS_W'(ndvi_mag);
    flag = 1'b0;
    prob = PROB_EXIT;
    leaf = 8'd0;
    if (ndsi < TQ_0P25) begin
      if (sf.cmp.b5_ge_0p072) begin
        if (sf.cmp.b3_lt_0p35) begin flag = 1'b0; prob = 7'd98; leaf = 8'd1; end
        else begin flag = 1'b1; prob = 7'd100; leaf = 8'd2; end
      end else if (sf.cmp.b1_lt_0p11) begin
        if (ndsi < TQ_0P21) begin flag = 1'b0; prob = 7'd98; leaf = 8'd31; end
        else if (sf.cmp.b3_lt_0p042) begin flag = 1'b0; prob = 7'd91; leaf = 8'd32; end
        else begin flag = 1'b1; prob = 7'd85; leaf = 8'd33; end
      end else begin
        if (ndsi < TQ_0P15) begin flag = 1'b0; prob = 7'd83; leaf = 8'd34; end
        else begin flag = 1'b1; prob = 7'd95; leaf = 8'd35; end
      end
    end else if (sf.cmp.b7_ge_0p14) begin
      if (sf.cmp.b4_lt_0p32) begin
        if (ndvi < TQ_0P19) begin
          if (sf.cmp.b1_lt_0p30) begin flag = 1'b0; prob = 7'd96; leaf = 8'd4; end
          else begin flag = 1'b1; prob = 7'd100; leaf = 8'd5; end
        end else begin flag = 1'b1; prob = 7'd91; leaf = 8'd6; end
      end else if (ndsi < TQ_0P57) begin
        if (ndvi < TQ_0P18) begin
          if (sf.cmp.b1_lt_0p35) begin flag = 1'b0; prob = 7'd79; leaf = 8'd7; end
          else if (sf.cmp.b7_ge_0p22) begin flag = 1'b0; prob = 7'd84; leaf = 8'd8; end
          else begin flag = 1'b1; prob = 7'd88; leaf = 8'd9; end
        end else begin flag = 1'b1; prob = 7'd95; leaf = 8'd10; end
      end else begin flag = 1'b1; prob = 7'd93; leaf = 8'd11; end
    end else if (sf.cmp.b5_ge_0p10) begin
      if (sf.cmp.b7_ge_0p11) begin
        if (sf.cmp.b1_lt_0p34) begin flag = 1'b0; prob = 7'd90; leaf = 8'd12; end
        else begin flag = 1'b1; prob = 7'd100; leaf = 8'd13; end
      end else begin flag = 1'b1; prob = 7'd81; leaf = 8'd14; end
    end else begin
      if (sf.cmp.b3_lt_0p0432) begin flag = 1'b0; prob = 7'd93; leaf = 8'd151; end
      else begin flag = 1'b1; prob = 7'd99; leaf = 8'd152; end
    end
    if (sf.cmp.hot && prob < PROB_FIRM) begin
      flag = 1'b0;
      prob = PROB_HOT;
      leaf = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_pixel_out_o <= sf.last;
      if (sf.masked) begin
        snow_flag_o    <= 1'b0;
        probability_o  <= PROB_MASKED;
        tree_leaf_o    <= 8'd0;
        ndsi_percent_o <= 8'd0;
        ndvi_percent_o <= 8'd0;
      end else if (sf.early) begin
        snow_flag_o    <= 1'b0;
        probability_o  <= PROB_EXIT;
        tree_leaf_o    <= 8'd0;
        ndsi_percent_o <= 8'd0;
        ndvi_percent_o <= 8'd0;
      end else begin
        snow_flag_o    <= flag;
        probability_o  <= prob;
        tree_leaf_o    <= leaf;
        ndsi_percent_o <= pct(sf.ndsi_neg, ndsi_mag);
        ndvi_percent_o <= pct(sf.ndvi_neg, ndvi_mag);
      end
    end
  end

endmodule

FILE: rtl/sptc_div.sv
module sptc_div import sptc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [NUM_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int RW = NUM_W + 1;

  logic [RW-1:0]    r_q   [FRAC_BITS+1];
  logic [NUM_W-1:0] d_q   [FRAC_BITS+1];
  logic [Q_W-1:0]   q_q   [FRAC_BITS+1];
  logic             sat_q [FRAC_BITS+1];

  logic          sat0;
  logic          ge0;
  logic [RW-1:0] r0;

  // A numerator of twice the denominator or more saturates the quotient.
  always_comb begin
    sat0 = {1'b0, num_i} >= {den_i, 1'b0};
    ge0  = num_i >= den_i;
    r0   = ge0 ? RW'(num_i - den_i) : RW'(num_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= r0;
      d_q[0]   <= den_i;
      q_q[0]   <= Q_W'(ge0);
      sat_q[0] <= sat0;
    end
  end

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_step
    logic [RW-1:0] r2;
    logic          ge;
    always_comb begin
      r2 = {r_q[i-1][RW-2:0], 1'b0};
      ge = r2 >= RW'(d_q[i-1]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i]   <= ge ? r2 - RW'(d_q[i-1]) : r2;
        d_q[i]   <= d_q[i-1];
        q_q[i]   <= {q_q[i-1][Q_W-2:0], ge};
        sat_q[i] <= sat_q[i-1];
      end
    end
  end

  assign quo_o = sat_q[FRAC_BITS] ? {Q_W{1'b1}} : q_q[FRAC_BITS];

endmodule

FILE: rtl/sptc_checker.sv
`include "snow_pixel_tree_classifier_unit_macros.svh"

module sptc_checker import sptc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       snow_flag_o,
  input logic [6:0] probability_o,
  input logic [7:0] tree_leaf_o,
  input logic [7:0] ndsi_percent_o,
  input logic [7:0] ndvi_percent_o
);

  // A result the receiver has not taken stays put.
  `SPTC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(probability_o) && $stable(tree_leaf_o) && $stable(snow_flag_o))

  // Masked and early-exit items carry no leaf, no flag and no percents.
  `SPTC_ASSERT_IMPL(a_exit_clean,
    out_valid_o && (probability_o == PROB_MASKED || probability_o == PROB_EXIT),
    !snow_flag_o && tree_leaf_o == 8'd0 && ndsi_percent_o == 8'd0 && ndvi_percent_o == 8'd0)

  // The thermal override clears the leaf and the flag.
  `SPTC_ASSERT_IMPL(a_hot_clean, out_valid_o && probability_o == PROB_HOT,
    !snow_flag_o && tree_leaf_o == 8'd0)

  // A leaf is reported only with a tree probability.
  `SPTC_ASSERT_IMPL(a_leaf_prob, out_valid_o && tree_leaf_o != 8'd0,
    probability_o >= 7'd79 && probability_o <= 7'd100)

endmodule

bind snow_pixel_tree_classifier_unit sptc_checker u_sptc_checker (.*);

FILE: verif/snow_pixel_tree_classifier_unit_tb.sv
`timescale 1ns / 1ps

module snow_pixel_tree_classifier_unit_tb;
  import sptc_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 200;

  typedef struct {
    logic signed [RAW_W-1:0] band [NBANDS];
    logic                    qa;
    logic                    last;
  } pixel_t;

  typedef struct {
    logic       flag;
    logic [6:0] prob;
    logic [7:0] leaf;
    logic [7:0] ndsi_pct;
    logic [7:0] ndvi_pct;
    logic       last;
  } verdict_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic signed [RAW_W-1:0] band_i [NBANDS];
  logic qa_masked_i, last_pixel_in_i;
  logic out_valid_o, out_ready_i;
  logic snow_flag_o, last_pixel_out_o;
  logic [6:0] probability_o;
  logic [7:0] tree_leaf_o, ndsi_percent_o, ndvi_percent_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  snow_pixel_tree_classifier_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .band_blue_i(band_i[B_BLUE]), .band_green_i(band_i[B_GREEN]),
    .band_red_i(band_i[B_RED]), .band_nir_i(band_i[B_NIR]),
    .band_swir1_i(band_i[B_SWIR1]), .band_thermal_i(band_i[B_THERMAL]),
    .band_swir2_i(band_i[B_SWIR2]),
    .qa_masked_i, .last_pixel_in_i, .out_valid_o, .out_ready_i,
    .snow_flag_o, .probability_o, .tree_leaf_o, .ndsi_percent_o,
    .ndvi_percent_o, .last_pixel_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Shadow copies of the block's registers.
  logic [31:0] refl_gain = 32'd429497;
  logic [31:0] temp_gain = 32'd429496730;
  logic [15:0] sat_raw = 16'd20000;

  pixel_t   pending_pixels [$];
  verdict_t expected_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit calm = 0;
  bit hold_req = 0, hold_done = 0;
  int unsigned hold_cnt = 0;
  int unsigned tx_gap = 0, rx_gap = 0;

  function automatic longint fx_const(longint n, longint d);
    return (n * (64'sd1 <<< FRAC_BITS) * 2 + d) / (2 * d);
  endfunction

  function automatic longint to_fixed(logic signed [RAW_W-1:0] raw, logic [31:0] k);
    longint p;
    p = longint'(raw) * longint'({32'b0, k});
    return p >>> (32 - FRAC_BITS);
  endfunction

  function automatic longint ratio(longint num, longint den);
    longint an, ad, q, r;
    bit neg;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    neg = (den == 0) ? (num < 0) : ((num < 0) != (den < 0));
    q = 0;
    if (an >= 2 * ad) begin
      q = (64'sd1 <<< (FRAC_BITS + 1)) - 1;
    end else begin
      r = an;
      if (r >= ad) begin
        q = 1;
        r -= ad;
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r <<< 1;
        q = q <<< 1;
        if (r >= ad) begin
          q |= 1;
          r -= ad;
        end
      end
    end
    return neg ? -q : q;
  endfunction

  function automatic logic [7:0] to_percent(longint q);
    longint v;
    if (q < 0) return 8'd0;
    v = (q * 100 + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic verdict_t classify(pixel_t px);
    verdict_t v;
    longint b [NBANDS];
    longint ndsi, ndvi;
    v = '{flag: 0, prob: PROB_MASKED, leaf: 0, ndsi_pct: 0, ndvi_pct: 0, last: px.last};
    if (px.qa) return v;
    v.prob = PROB_EXIT;
    for (int i = 0; i < NBANDS; i++) begin
      if (i == B_THERMAL) b[i] = to_fixed(px.band[i], temp_gain);
      else if (px.band[i] == sat_raw) b[i] = 64'sd1 <<< FRAC_BITS;
      else b[i] = to_fixed(px.band[i], refl_gain);
    end
    // Water, hot pixel and empty quotient exits.
    if (b[B_NIR] < fx_const(11, 100)) return v;
    if (b[B_THERMAL] > fx_const(2485, 100)) return v;
    if (b[B_GREEN] == 0 && b[B_SWIR1] == 0) return v;
    ndsi = ratio(b[B_GREEN] - b[B_SWIR1], b[B_GREEN] + b[B_SWIR1]);
    if (b[B_RED] == 0 && b[B_NIR] == 0) return v;
    ndvi = ratio(b[B_NIR] - b[B_RED], b[B_NIR] + b[B_RED]);

    if (ndsi < fx_const(25, 100)) begin
      if (b[B_SWIR1] >= fx_const(72, 1000)) begin
        if (b[B_RED] < fx_const(35, 100)) v = '{0, 98, 1, 0, 0, px.last};
        else v = '{1, 100, 2, 0, 0, px.last};
      end else if (b[B_BLUE] < fx_const(11, 100)) begin
        if (ndsi < fx_const(21, 100)) v = '{0, 98, 31, 0, 0, px.last};
        else if (b[B_RED] < fx_const(42, 1000)) v = '{0, 91, 32, 0, 0, px.last};
        else v = '{1, 85, 33, 0, 0, px.last};
      end else begin
        if (ndsi < fx_const(15, 100)) v = '{0, 83, 34, 0, 0, px.last};
        else v = '{1, 95, 35, 0, 0, px.last};
      end
    end else if (b[B_SWIR2] >= fx_const(14, 100)) begin
      if (b[B_NIR] < fx_const(32, 100)) begin
        if (ndvi < fx_const(19, 100)) begin
          if (b[B_BLUE] < fx_const(30, 100)) v = '{0, 96, 4, 0, 0, px.last};
          else v = '{1, 100, 5, 0, 0, px.last};
        end else v = '{1, 91, 6, 0, 0, px.last};
      end else if (ndsi < fx_const(57, 100)) begin
        if (ndvi < fx_const(18, 100)) begin
          if (b[B_BLUE] < fx_const(35, 100)) v = '{0, 79, 7, 0, 0, px.last};
          else if (b[B_SWIR2] >= fx_const(22, 100)) v = '{0, 84, 8, 0, 0, px.last};
          else v = '{1, 88, 9, 0, 0, px.last};
        end else v = '{1, 95, 10, 0, 0, px.last};
      end else v = '{1, 93, 11, 0, 0, px.last};
    end else if (b[B_SWIR1] >= fx_const(10, 100)) begin
      if (b[B_SWIR2] >= fx_const(11, 100)) begin
        if (b[B_BLUE] < fx_const(34, 100)) v = '{0, 90, 12, 0, 0, px.last};
        else v = '{1, 100, 13, 0, 0, px.last};
      end else v = '{1, 81, 14, 0, 0, px.last};
    end else begin
      if (b[B_RED] < fx_const(432, 10000)) v = '{0, 93, 151, 0, 0, px.last};
      else v = '{1, 99, 152, 0, 0, px.last};
    end
    // A warm pixel overrides any leaf that is not firm.
    if (b[B_THERMAL] > fx_const(1885, 100) && v.prob < PROB_FIRM) begin
      v.flag = 0;
      v.prob = PROB_HOT;
      v.leaf = 0;
    end
    v.ndsi_pct = to_percent(ndsi);
    v.ndvi_pct = to_percent(ndvi);
    return v;
  endfunction

  // Mostly plausible scenes, with some fully random and special pixels mixed in.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int unsigned style;
    style = $urandom_range(0, 99);
    for (int i = 0; i < NBANDS; i++) begin
      if (style < 70) px.band[i] = $urandom_range(0, 12000);
      else px.band[i] = $urandom;
    end
    if (style < 70) px.band[B_THERMAL] = $signed($urandom_range(0, 700)) - 400;
    if (style < 70 && $urandom_range(0, 3) == 0) px.band[B_SWIR1] = $urandom_range(0, 1200);
    if (style < 70 && $urandom_range(0, 3) == 0) px.band[B_SWIR2] = $urandom_range(0, 2500);
    if ($urandom_range(0, 9) == 0) px.band[$urandom_range(0, NBANDS - 1)] = sat_raw;
    if ($urandom_range(0, 24) == 0) begin
      px.band[B_GREEN] = $urandom_range(0, 3000);
      px.band[B_SWIR1] = -px.band[B_GREEN];
    end
    if ($urandom_range(0, 29) == 0) begin
      px.band[B_GREEN] = 0;
      px.band[B_SWIR1] = 0;
    end
    px.qa = ($urandom_range(0, 14) == 0);
    px.last = $urandom_range(0, 1);
    return px;
  endfunction

  function automatic pixel_t make_pixel(int bl, int gr, int rd, int ni, int s1, int th, int s2);
    pixel_t px;
    px.band[B_BLUE] = bl;
    px.band[B_GREEN] = gr;
    px.band[B_RED] = rd;
    px.band[B_NIR] = ni;
    px.band[B_SWIR1] = s1;
    px.band[B_THERMAL] = th;
    px.band[B_SWIR2] = s2;
    px.qa = 0;
    px.last = 0;
    return px;
  endfunction

  // Each write deasserts cfg_valid_i before the next one starts.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_REFL_SCALE: refl_gain = data;
      CFG_TEMP_SCALE: temp_gain = data;
      CFG_SAT_CODE:   sat_raw = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: predicts on acceptance, then offers the next pending item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pixel_t px;
        px.band = band_i;
        px.qa = qa_masked_i;
        px.last = last_pixel_in_i;
        expected_verdicts.push_back(classify(px));
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          pixel_t px;
          px = pending_pixels.pop_front();
          band_i <= px.band;
          qa_masked_i <= px.qa;
          last_pixel_in_i <= px.last;
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 12);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here alone.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt++;
      if (hold_cnt >= LONG_HOLD) hold_done <= 1'b1;
    end
  end

  // Receiver: checks each result item against the oldest prediction.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
        end else begin
          verdict_t e;
          e = expected_verdicts.pop_front();
          if (snow_flag_o !== e.flag || probability_o !== e.prob || tree_leaf_o !== e.leaf ||
              ndsi_percent_o !== e.ndsi_pct || ndvi_percent_o !== e.ndvi_pct ||
              last_pixel_out_o !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp flag %0d prob %0d leaf %0d ndsi %0d ndvi %0d",
                        " last %0d, got %0d %0d %0d %0d %0d %0d"},
                       e.flag, e.prob, e.leaf, e.ndsi_pct, e.ndvi_pct, e.last,
                       snow_flag_o, probability_o, tree_leaf_o, ndsi_percent_o,
                       ndvi_percent_o, last_pixel_out_o);
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) rx_gap = $urandom_range(1, 12);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_REFL_SCALE;
    cfg_data_i = '0;
    qa_masked_i = 1'b0;
    last_pixel_in_i = 1'b0;
    for (int i = 0; i < NBANDS; i++) band_i[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels under reset settings.
    begin
      pixel_t px;
      px = make_pixel(500, 800, 700, 5000, 300, 0, 200);
      px.qa = 1;
      px.last = 1;
      pending_pixels.push_back(px);
      pending_pixels.push_back(make_pixel(500, 800, 700, 500, 300, 0, 200));    // water
      pending_pixels.push_back(make_pixel(500, 800, 700, 5000, 300, 300, 200)); // hot
      pending_pixels.push_back(make_pixel(500, 0, 700, 5000, 0, 0, 200));       // no snow quotient
      pending_pixels.push_back(make_pixel(500, 3000, 700, 5000, -3000, 0, 200));
      pending_pixels.push_back(make_pixel(20000, 20000, 20000, 20000, 20000, 0, 20000));
      pending_pixels.push_back(make_pixel(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
      pending_pixels.push_back(make_pixel(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      pending_pixels.push_back(make_pixel(800, 5000, 3000, 3500, 500, 0, 1000));
      pending_pixels.push_back(make_pixel(500, 2000, 1000, 2500, 300, 0, 3000));
      pending_pixels.push_back(make_pixel(4000, 2000, 1000, 2500, 300, 0, 3000));
      pending_pixels.push_back(make_pixel(1000, 2000, 1000, 2000, 1500, 0, 1500));
      pending_pixels.push_back(make_pixel(1000, 2000, 1000, 2000, 1500, 200, 1000));
      pending_pixels.push_back(make_pixel(5000, 6000, 500, 4000, 3000, 0, 2500));
      pending_pixels.push_back(make_pixel(3000, 8000, 1000, 3500, 100, 0, 500));
      pending_pixels.push_back(make_pixel(500, 2000, 300, 3000, 100, 0, 500));
      pending_pixels.push_back(make_pixel(500, 2000, 3000, 3000, 1500, 200, 500));
      pending_pixels.push_back(make_pixel(2000, 3000, 1000, 3000, 2000, 0, 100));
    end
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_REFL_SCALE, 32'hFFFF_FFFF);
          write_reg(CFG_TEMP_SCALE, 32'd0);
          write_reg(CFG_SAT_CODE, 32'h0000_8000);
        end
        1: begin
          write_reg(CFG_REFL_SCALE, 32'd0);
          write_reg(CFG_TEMP_SCALE, 32'hFFFF_FFFF);
          write_reg(CFG_SAT_CODE, 32'h0000_7FFF);
          write_reg(CFG_SPARE, 32'hDEAD_BEEF);
        end
        2: begin
          write_reg(CFG_REFL_SCALE, 32'd429497);
          write_reg(CFG_TEMP_SCALE, 32'd429496730);
          write_reg(CFG_SAT_CODE, 32'd20000);
          hold_req <= 1'b1;
        end
        3: begin
          write_reg(CFG_REFL_SCALE, 32'd400000 + $urandom_range(0, 60000));
          write_reg(CFG_TEMP_SCALE, 32'd380000000 + $urandom_range(0, 90000000));
          write_reg(CFG_SAT_CODE, $urandom_range(0, 12000));
        end
        default: begin
          write_reg(CFG_REFL_SCALE, 32'd429497);
          write_reg(CFG_TEMP_SCALE, 32'd429496730);
          write_reg(CFG_SAT_CODE, 32'd16000);
          calm = 1;
        end
      endcase
      repeat (phase < 2 ? 120 : 270) pending_pixels.push_back(random_pixel());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sptc_pkg.sv
rtl/sptc_div.sv
rtl/snow_pixel_tree_classifier_unit.sv
rtl/sptc_checker.sv
verif/snow_pixel_tree_classifier_unit_tb.sv
